// File: rtl/tlb_page_table_translator_macros.svh
// Assertion macros for the TLB and page table translator.
// Used by the top level only; no other dependencies.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// same-cycle implication under the asynchronous reset
`define TLBPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the asynchronous reset
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tlbpt_pkg.sv
// Shared constants and types of the TLB and page table translator.
// No dependencies.
package tlbpt_pkg;

	localparam int TLB_ENTRIES_DEF     = 16;
	localparam int VIRTUAL_PAGES_DEF   = 1024;
	localparam int PHYSICAL_FRAMES_DEF = 256;
	localparam int OFFSET_WIDTH_DEF    = 10;

	localparam int VA_W    = 20;
	localparam int PA_W    = 18;
	localparam int STAMP_W = 32;

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_LRU  = 1'b1;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_READ  = 8'b0000_0100,
		ST_CHECK = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_UNMAP = 8'b0010_0000,
		ST_MAP   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/tlb_page_table_translator.sv
// Virtual to physical translator: FIFO-filled TLB in flops, page table and stamps in one RAM.
// Depends on tlbpt_pkg, tlbpt_ram and tlb_page_table_translator_macros.svh.
//
// channel  direction  handshake               payload
// in       to block   in_valid / in_stall      virtual_address
// out      from block out_valid / out_stall    phys_addr, tlb_hit, page_fault
// cfg      to block   cfg_valid / cfg_ready    replacement_mode
//
// TLB hit or mapped page: read, check, load; the load waits until the output register is free.
// FIFO fault, or LRU fault while frames remain: unmap sweep of the table, then map and load.
// LRU fault once all frames are used: stamp scan, then unmap sweep, then map and load.
// After reset a clearing pass runs through every table entry; in_stall stays high.
// One item is in work at a time; the next is taken while a result still waits on out_stall.

`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES     = tlbpt_pkg::TLB_ENTRIES_DEF,
	parameter int VIRTUAL_PAGES   = tlbpt_pkg::VIRTUAL_PAGES_DEF,
	parameter int PHYSICAL_FRAMES = tlbpt_pkg::PHYSICAL_FRAMES_DEF,
	parameter int OFFSET_WIDTH    = tlbpt_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        replacement_mode,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tlbpt_pkg::VA_W-1:0]  virtual_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tlbpt_pkg::PA_W-1:0]  phys_addr,
	output logic                        tlb_hit,
	output logic                        page_fault
);

	localparam int PW  = $clog2(VIRTUAL_PAGES);
	localparam int FW  = $clog2(PHYSICAL_FRAMES);
	localparam int SW  = $clog2(TLB_ENTRIES);
	localparam int CW  = $clog2(TLB_ENTRIES + 1);
	localparam int FCW = $clog2(PHYSICAL_FRAMES + 2);
	localparam int TW  = tlbpt_pkg::STAMP_W;
	localparam int EW  = 1 + FW + TW;

	tlbpt_pkg::state_t state_q;

	logic                    mode_q;
	logic [PW-1:0]           page_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic [TW-1:0]           acc_q;
	logic [TW-1:0]           stamp_q;
	logic [FW-1:0]           frame_q;
	logic [FW-1:0]           next_free_q;
	logic [FCW-1:0]          fault_count_q;
	logic                    hit_q;
	logic                    fault_q;
	logic [FW-1:0]           tlb_frame_q;
	logic [PW:0]             idx_q;
	logic                    found_q;
	logic [TW-1:0]           best_stamp_q;
	logic [FW-1:0]           best_frame_q;
	logic                    rvalid_s1;
	logic [PW-1:0]           rpage_s1;

	logic [PW-1:0] tag_q   [TLB_ENTRIES];
	logic [FW-1:0] tframe_q [TLB_ENTRIES];
	logic [CW-1:0] tlb_count_q;
	logic [SW-1:0] tlb_next_q;

	logic                    out_valid_q;
	logic [tlbpt_pkg::PA_W-1:0] pa_q;
	logic                    hit_out_q;
	logic                    fault_out_q;

	// table RAM
	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [PW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic          rd_valid;
	logic [FW-1:0] rd_frame;
	logic [TW-1:0] rd_stamp;
	logic [TW-1:0] stamp_n;
	logic [FCW-1:0] fault_count_n;

	logic          lk_hit;
	logic [FW-1:0] lk_frame;

	logic          best_upd;
	logic [FW-1:0] best_frame_n;
	logic          sweep_end;
	logic          out_free;
	logic [FW+OFFSET_WIDTH-1:0] pa_full;

	logic [PW-1:0] in_page;

	assign rd_valid = ram_rdata[EW-1];
	assign rd_frame = ram_rdata[TW +: FW];
	assign rd_stamp = ram_rdata[TW-1:0];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != tlbpt_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign phys_addr  = pa_q;
	assign tlb_hit    = hit_out_q;
	assign page_fault = fault_out_q;

	// page number is taken modulo the page count (a power of two)
	assign in_page = PW'(virtual_address >> OFFSET_WIDTH);

	assign stamp_n       = (mode_q == tlbpt_pkg::MODE_LRU) ? acc_q : rd_stamp;
	assign fault_count_n = (fault_count_q == FCW'(PHYSICAL_FRAMES + 1)) ?
		fault_count_q : fault_count_q + 1'b1;

	assign best_upd     = rvalid_s1 && rd_valid && (!found_q || rd_stamp < best_stamp_q);
	assign best_frame_n = best_upd ? rd_frame : best_frame_q;
	assign sweep_end    = (idx_q == (PW+1)'(VIRTUAL_PAGES));
	assign pa_full      = {frame_q, offset_q};

	// TLB search, oldest slot first
	always_comb begin
		logic [SW-1:0] start_v;
		logic [SW:0]   slot_v;
		lk_hit   = 1'b0;
		lk_frame = '0;
		start_v  = (tlb_count_q == CW'(TLB_ENTRIES)) ? tlb_next_q : '0;
		for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
			slot_v = (SW+1)'(start_v) + (SW+1)'(k);
			if (slot_v >= (SW+1)'(TLB_ENTRIES)) begin
				slot_v = slot_v - (SW+1)'(TLB_ENTRIES);
			end
			if (CW'(k) < tlb_count_q && tag_q[slot_v[SW-1:0]] == page_q) begin
				lk_hit   = 1'b1;
				lk_frame = tframe_q[slot_v[SW-1:0]];
			end
		end
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = page_q;
		ram_wdata = {rd_valid, rd_frame, stamp_n};
		ram_raddr = page_q;
		unique case (state_q)
			tlbpt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[PW-1:0];
				ram_wdata = '0;
			end
			tlbpt_pkg::ST_CHECK: begin
				ram_we = hit_q || rd_valid;
			end
			tlbpt_pkg::ST_SCAN: begin
				ram_raddr = idx_q[PW-1:0];
			end
			tlbpt_pkg::ST_UNMAP: begin
				ram_raddr = idx_q[PW-1:0];
				ram_waddr = rpage_s1;
				ram_wdata = {1'b0, rd_frame, rd_stamp};
				ram_we    = rvalid_s1 && rd_valid && (rd_frame == frame_q);
			end
			tlbpt_pkg::ST_MAP: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, frame_q, stamp_q};
			end
			default: begin
			end
		endcase
	end

	tlbpt_ram #(
		.WIDTH(EW),
		.DEPTH(VIRTUAL_PAGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == tlbpt_pkg::ST_IDLE) begin
			page_q   <= in_page;
			offset_q <= virtual_address[OFFSET_WIDTH-1:0];
		end
		if (state_q == tlbpt_pkg::ST_READ) begin
			tlb_frame_q <= lk_frame;
		end
		if (state_q == tlbpt_pkg::ST_CHECK) begin
			stamp_q <= stamp_n;
		end
		rpage_s1 <= idx_q[PW-1:0];
		if (state_q == tlbpt_pkg::ST_DONE && out_free) begin
			pa_q        <= tlbpt_pkg::PA_W'(pa_full);
			hit_out_q   <= hit_q;
			fault_out_q <= fault_q;
		end
		if (state_q == tlbpt_pkg::ST_DONE && out_free && !hit_q) begin
			tag_q[tlb_next_q]    <= page_q;
			tframe_q[tlb_next_q] <= frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tlbpt_pkg::ST_CLEAR;
			mode_q        <= tlbpt_pkg::MODE_FIFO;
			acc_q         <= '0;
			frame_q       <= '0;
			next_free_q   <= '0;
			fault_count_q <= '0;
			hit_q         <= 1'b0;
			fault_q       <= 1'b0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			best_stamp_q  <= '0;
			best_frame_q  <= '0;
			rvalid_s1     <= 1'b0;
			tlb_count_q   <= '0;
			tlb_next_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= replacement_mode;
			end
			// set on load, drop once the held result transfers
			if (state_q == tlbpt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			rvalid_s1 <= (state_q == tlbpt_pkg::ST_SCAN || state_q == tlbpt_pkg::ST_UNMAP)
				&& !sweep_end;

			unique case (state_q)
				tlbpt_pkg::ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[PW-1:0] == PW'(VIRTUAL_PAGES - 1)) begin
						state_q <= tlbpt_pkg::ST_IDLE;
					end
				end
				tlbpt_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (acc_q != tlbpt_pkg::STAMP_MAX) begin
							acc_q <= acc_q + 1'b1;
						end
						state_q <= tlbpt_pkg::ST_READ;
					end
				end
				tlbpt_pkg::ST_READ: begin
					hit_q   <= lk_hit;
					state_q <= tlbpt_pkg::ST_CHECK;
				end
				tlbpt_pkg::ST_CHECK: begin
					idx_q        <= '0;
					found_q      <= 1'b0;
					best_stamp_q <= '0;
					best_frame_q <= '0;
					fault_q      <= 1'b0;
					if (hit_q) begin
						frame_q <= tlb_frame_q;
						state_q <= tlbpt_pkg::ST_DONE;
					end else if (rd_valid) begin
						frame_q <= rd_frame;
						state_q <= tlbpt_pkg::ST_DONE;
					end else begin
						fault_q       <= 1'b1;
						fault_count_q <= fault_count_n;
						if (mode_q == tlbpt_pkg::MODE_FIFO) begin
							frame_q     <= next_free_q;
							next_free_q <= (next_free_q == FW'(PHYSICAL_FRAMES - 1)) ?
								'0 : next_free_q + 1'b1;
							state_q     <= tlbpt_pkg::ST_UNMAP;
						end else if (fault_count_n > FCW'(PHYSICAL_FRAMES)) begin
							state_q <= tlbpt_pkg::ST_SCAN;
						end else begin
							frame_q <= FW'(fault_count_n - 1'b1);
							state_q <= tlbpt_pkg::ST_UNMAP;
						end
					end
				end
				tlbpt_pkg::ST_SCAN: begin
					if (best_upd) begin
						found_q      <= 1'b1;
						best_stamp_q <= rd_stamp;
						best_frame_q <= rd_frame;
					end
					if (sweep_end) begin
						frame_q <= best_frame_n;
						idx_q   <= '0;
						state_q <= tlbpt_pkg::ST_UNMAP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tlbpt_pkg::ST_UNMAP: begin
					if (sweep_end) begin
						state_q <= tlbpt_pkg::ST_MAP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tlbpt_pkg::ST_MAP: begin
					state_q <= tlbpt_pkg::ST_DONE;
				end
				tlbpt_pkg::ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						if (!hit_q) begin
							tlb_next_q <= (tlb_next_q == SW'(TLB_ENTRIES - 1)) ?
								'0 : tlb_next_q + 1'b1;
							if (tlb_count_q != CW'(TLB_ENTRIES)) begin
								tlb_count_q <= tlb_count_q + 1'b1;
							end
						end
						state_q <= tlbpt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tlbpt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`TLBPT_ASSERT_NOW(a_hit_no_fault, clk, arst_n, out_valid_q && hit_out_q, !fault_out_q, "hit+fault")
	`TLBPT_ASSERT_NOW(a_tlb_count, clk, arst_n, 1'b1, tlb_count_q <= CW'(TLB_ENTRIES), "TLB overfill")
	`TLBPT_ASSERT_NOW(a_fault_count, clk, arst_n, 1'b1, fault_count_q <= FCW'(PHYSICAL_FRAMES + 1), "faults")
	`TLBPT_ASSERT_NEXT(a_accept_lookup, clk, arst_n, in_valid && !in_stall, state_q == tlbpt_pkg::ST_READ && in_stall, "no lookup")

endmodule

// File: rtl/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: test/tlb_page_table_translator_checker.sv
`timescale 1ns / 100ps
// Checker for the TLB and page table translator: watches all three channels,
// predicts each translation and compares results in order. Depends on tlbpt_pkg.
module tlb_page_table_translator_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        replacement_mode,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [tlbpt_pkg::VA_W-1:0]  virtual_address,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [tlbpt_pkg::PA_W-1:0]  phys_addr,
	input  logic                        tlb_hit,
	input  logic                        page_fault,
	output int                          fail_count,
	output int                          pending,
	output int                          hit_total,
	output int                          fault_total
);

	localparam int TLB_N    = tlbpt_pkg::TLB_ENTRIES_DEF;
	localparam int PAGES    = tlbpt_pkg::VIRTUAL_PAGES_DEF;
	localparam int FRAMES   = tlbpt_pkg::PHYSICAL_FRAMES_DEF;
	localparam int OFF_W    = tlbpt_pkg::OFFSET_WIDTH_DEF;

	typedef struct packed {
		logic [tlbpt_pkg::PA_W-1:0] phys;
		logic                       hit;
		logic                       fault;
	} translation_t;

	translation_t expected_translations[$];

	logic                          mode;
	logic [9:0]                    tlb_tag [TLB_N];
	logic [7:0]                    tlb_frame [TLB_N];
	int                            tlb_fill;
	int                            tlb_next;
	logic [7:0]                    frame_of [PAGES];
	bit                            mapped [PAGES];
	logic [tlbpt_pkg::STAMP_W-1:0] stamp [PAGES];
	logic [tlbpt_pkg::STAMP_W-1:0] accesses;
	logic [7:0]                    fifo_frame;
	int                            faults_seen;

	function automatic translation_t translate(logic [tlbpt_pkg::VA_W-1:0] va);
		translation_t r;
		logic [9:0] page;
		logic [7:0] frame;
		logic [tlbpt_pkg::STAMP_W-1:0] best;
		bit found;
		int n;
		int start;
		int slot;
		page = va[tlbpt_pkg::VA_W-1:OFF_W];
		frame = '0;
		r.hit = 1'b0;
		r.fault = 1'b0;
		if (accesses != tlbpt_pkg::STAMP_MAX)
			accesses++;
		if (mode == tlbpt_pkg::MODE_LRU)
			stamp[page] = accesses;
		n = (tlb_fill < TLB_N) ? tlb_fill : TLB_N;
		start = (tlb_fill < TLB_N) ? 0 : tlb_next;
		for (int k = 0; k < n; k++) begin
			slot = (start + k) % TLB_N;
			if (!r.hit && tlb_tag[slot] == page) begin
				r.hit = 1'b1;
				frame = tlb_frame[slot];
			end
		end
		if (!r.hit) begin
			if (mapped[page]) begin
				frame = frame_of[page];
			end else begin
				r.fault = 1'b1;
				if (faults_seen < FRAMES + 1)
					faults_seen++;
				if (mode == tlbpt_pkg::MODE_FIFO) begin
					frame = fifo_frame;
					fifo_frame = fifo_frame + 8'd1;
				end else if (faults_seen > FRAMES) begin
					// oldest stamp wins, lowest page on a tie
					found = 0;
					best = '0;
					for (int p = 0; p < PAGES; p++) begin
						if (mapped[p] && (!found || stamp[p] < best)) begin
							found = 1;
							best = stamp[p];
							frame = frame_of[p];
						end
					end
				end else begin
					frame = 8'(faults_seen - 1);
				end
				for (int p = 0; p < PAGES; p++)
					if (mapped[p] && frame_of[p] == frame)
						mapped[p] = 0;
				frame_of[page] = frame;
				mapped[page] = 1;
			end
			tlb_tag[tlb_next] = page;
			tlb_frame[tlb_next] = frame;
			tlb_next = (tlb_next + 1) % TLB_N;
			if (tlb_fill < TLB_N)
				tlb_fill++;
		end
		r.phys = {frame, va[OFF_W-1:0]};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		translation_t want;
		translation_t got;
		if (!arst_n) begin
			mode = tlbpt_pkg::MODE_FIFO;
			tlb_fill = 0;
			tlb_next = 0;
			accesses = '0;
			fifo_frame = '0;
			faults_seen = 0;
			for (int p = 0; p < PAGES; p++) begin
				mapped[p] = 0;
				stamp[p] = '0;
				frame_of[p] = '0;
			end
			expected_translations.delete();
			fail_count = 0;
			hit_total = 0;
			fault_total = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode = replacement_mode;
			if (out_valid && !out_stall) begin
				got = '{phys_addr, tlb_hit, page_fault};
				if (expected_translations.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result pa=%h hit=%b fault=%b",
							phys_addr, tlb_hit, page_fault);
				end else begin
					want = expected_translations.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected pa=%h hit=%b fault=%b, got pa=%h hit=%b fault=%b",
								want.phys, want.hit, want.fault, got.phys, got.hit, got.fault);
					end
					hit_total += got.hit;
					fault_total += got.fault;
				end
			end
			if (in_valid && !in_stall)
				expected_translations.push_back(translate(virtual_address));
		end
		pending = expected_translations.size();
	end

endmodule

// File: test/tlb_page_table_translator_test.sv
`timescale 1ns / 100ps
// Top of the translator testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on tlbpt_pkg, the translator and tlb_page_table_translator_checker.
module tlb_page_table_translator_test;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 645;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic                        replacement_mode = tlbpt_pkg::MODE_FIFO;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [tlbpt_pkg::VA_W-1:0]  virtual_address = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [tlbpt_pkg::PA_W-1:0]  phys_addr;
	logic                        tlb_hit;
	logic                        page_fault;

	int fail_count;
	int pending;
	int hit_total;
	int fault_total;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int recent_pages[$];

	always #5 clk = ~clk;

	tlb_page_table_translator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .replacement_mode(replacement_mode),
		.in_valid(in_valid), .in_stall(in_stall), .virtual_address(virtual_address),
		.out_valid(out_valid), .out_stall(out_stall), .phys_addr(phys_addr),
		.tlb_hit(tlb_hit), .page_fault(page_fault)
	);

	tlb_page_table_translator_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .replacement_mode(replacement_mode),
		.in_valid(in_valid), .in_stall(in_stall), .virtual_address(virtual_address),
		.out_valid(out_valid), .out_stall(out_stall), .phys_addr(phys_addr),
		.tlb_hit(tlb_hit), .page_fault(page_fault),
		.fail_count(fail_count), .pending(pending),
		.hit_total(hit_total), .fault_total(fault_total)
	);

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// end the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic translate_address(input logic [tlbpt_pkg::VA_W-1:0] va);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		replacement_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly revisit recent pages so the TLB and table see hits; fresh pages may fault
	function automatic logic [tlbpt_pkg::VA_W-1:0] pick_address();
		int page;
		if (recent_pages.size() == 0 || $urandom_range(99) < 16) begin
			page = $urandom_range(tlbpt_pkg::VIRTUAL_PAGES_DEF - 1);
			recent_pages.push_back(page);
			if (recent_pages.size() > 24)
				void'(recent_pages.pop_front());
		end else begin
			page = recent_pages[$urandom_range(recent_pages.size() - 1)];
		end
		return {10'(page), 10'($urandom_range(1023))};
	endfunction

	task automatic random_phase(input logic m, input int idle, input int stall);
		drain();
		write_mode(m);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 300)
				drain();
			translate_address(pick_address());
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		write_mode(tlbpt_pkg::MODE_FIFO);
		// directed: field extremes, TLB hit, table hit after TLB turnover, faults
		translate_address(20'h00000);
		translate_address(20'h003FF);
		translate_address(20'hFFFFF);
		translate_address(20'hFFC00);
		translate_address(20'h55555);
		translate_address(20'hAAAAA);
		for (int i = 0; i < 16; i++)
			translate_address({10'(i + 1), 10'(i * 61)});
		translate_address(20'h00123);
		translate_address(20'hFFFFF);
		drain();
		write_mode(tlbpt_pkg::MODE_LRU);
		translate_address(20'hFFC01);
		translate_address(20'h12345);
		translate_address(20'h12345);
		random_phase(tlbpt_pkg::MODE_FIFO, 12, 77);
		random_phase(tlbpt_pkg::MODE_LRU, 77, 12);
		random_phase(tlbpt_pkg::MODE_LRU, 0, 0);
		drain();
		repeat (2200) @(posedge clk);
		$display("Covered %0d TLB hits and %0d page faults in FIFO and LRU frame replacement,",
			hit_total, fault_total);
		$display("with sender and receiver stalls in both directions and back-to-back runs.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tlbpt_pkg.sv
rtl/tlbpt_ram.sv
rtl/tlb_page_table_translator.sv
test/tlb_page_table_translator_checker.sv
test/tlb_page_table_translator_test.sv
